// ===== design/mmcq_pkg.sv =====
// Types, codes and helper functions shared by the mouse motion credit queue.
package mmcq_pkg;

  localparam logic [1:0] MODE_MOTION  = 2'd0;
  localparam logic [1:0] MODE_ACK     = 2'd1;
  localparam logic [1:0] MODE_PRESS   = 2'd2;
  localparam logic [1:0] MODE_RELEASE = 2'd3;

  localparam logic [1:0] MSG_MOTION  = 2'd0;
  localparam logic [1:0] MSG_PRESS   = 2'd1;
  localparam logic [1:0] MSG_RELEASE = 2'd2;
  localparam logic [1:0] MSG_DROP    = 2'd3;

  localparam logic [3:0] BTN_LEFT   = 4'd1;
  localparam logic [3:0] BTN_MIDDLE = 4'd2;
  localparam logic [3:0] BTN_RIGHT  = 4'd3;

  localparam logic [3:0] BURST_RESET = 4'd4;
  localparam logic [3:0] MAX_BURST   = 4'd8;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic [3:0]         button_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         msg_kind;
    logic signed [15:0] out_dx;
    logic signed [15:0] out_dy;
    logic [3:0]         out_button;
    logic [2:0]         out_mask;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [2:0]         mask;
  } ring_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_pend;
    logic rd_issue;
    logic load_rd;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic drain;
    logic out_free;
    logic cnt_zero;
  } status_t;

  function automatic logic [2:0] button_bit(input logic [3:0] id);
    logic [2:0] b;
    b = 3'b000;
    if (id == BTN_LEFT) b = 3'b001;
    if (id == BTN_MIDDLE) b = 3'b010;
    if (id == BTN_RIGHT) b = 3'b100;
    return b;
  endfunction

  function automatic logic [3:0] effective_limit(input logic [3:0] lim);
    logic [3:0] e;
    e = lim;
    if (lim == 4'd0) e = 4'd1;
    if (lim > MAX_BURST) e = MAX_BURST;
    return e;
  endfunction

endpackage

// ===== design/mmcq_ctrl.sv =====
// Controller state machine: accept, single-result emit and ring drain sequencing.
module mmcq_ctrl
  import mmcq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.emit) begin
            state_nxt = ST_EMIT;
          end else if (status.drain) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_EMIT: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_nxt = status.cnt_zero ? ST_IDLE : ST_READ;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.accept = in_valid;
      end
      ST_EMIT: cmd.load_pend = status.out_free;
      ST_READ: cmd.rd_issue = 1'b1;
      ST_LOAD: cmd.load_rd = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== design/mmcq_datapath.sv =====
// Datapath: ring buffer, credit and fill counters, button mask and output register.
module mmcq_datapath
  import mmcq_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [3:0] cfg_wdata,
  input  logic      out_stall,
  input  cmd_t      cmd,
  output status_t   status,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > 4) ? FILL_W : 4;

  ring_entry_t ring [RING_DEPTH];

  logic [3:0]       burst_r, burst_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [3:0]       outst_r, outst_nxt;
  logic [2:0]       held_r, held_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  out_item_t        pend_r, pend_nxt;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  ring_entry_t      rd_data_r;
  ring_entry_t      wr_entry;

  logic [3:0]       lim;
  logic             busy;
  logic             full;
  logic             ring_we;
  logic [CMP_W-1:0] fill_cmp;
  logic [CMP_W-1:0] lim_cmp;
  logic [3:0]       sent;

  assign lim      = effective_limit(burst_r);
  assign busy     = outst_r >= lim;
  assign full     = fill_r == FILL_W'(RING_DEPTH);
  assign fill_cmp = CMP_W'(fill_r);
  assign lim_cmp  = CMP_W'(lim);
  assign sent     = (fill_cmp < lim_cmp) ? 4'(fill_cmp) : lim;
  assign ring_we  = cmd.accept && (in_data.mode == MODE_MOTION) && busy && !full;

  assign wr_entry.dx   = in_data.delta_x;
  assign wr_entry.dy   = in_data.delta_y;
  assign wr_entry.mask = held_r;

  assign status.emit     = !((in_data.mode == MODE_ACK) ||
                             ((in_data.mode == MODE_MOTION) && busy && !full));
  assign status.drain    = (in_data.mode == MODE_ACK) && (sent != 4'd0);
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.cnt_zero = cnt_r == 4'd0;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    burst_nxt     = cfg_we ? cfg_wdata : burst_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    fill_nxt      = fill_r;
    outst_nxt     = outst_r;
    held_nxt      = held_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.accept) begin
      pend_nxt            = '0;
      pend_nxt.last       = 1'b1;
      pend_nxt.out_mask   = held_r;
      case (in_data.mode)
        MODE_MOTION: begin
          if (!busy) begin
            outst_nxt          = outst_r + 4'd1;
            pend_nxt.msg_kind  = MSG_MOTION;
            pend_nxt.out_dx    = in_data.delta_x;
            pend_nxt.out_dy    = in_data.delta_y;
          end else if (full) begin
            pend_nxt.msg_kind  = MSG_DROP;
          end else begin
            wr_idx_nxt = (wr_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_r + IDX_W'(1);
            fill_nxt   = fill_r + FILL_W'(1);
          end
        end
        MODE_ACK: begin
          outst_nxt = sent;
          cnt_nxt   = sent;
        end
        MODE_PRESS: begin
          held_nxt            = held_r | button_bit(in_data.button_id);
          pend_nxt.msg_kind   = MSG_PRESS;
          pend_nxt.out_button = in_data.button_id;
          pend_nxt.out_mask   = held_nxt;
        end
        default: begin
          held_nxt            = held_r & ~button_bit(in_data.button_id);
          pend_nxt.msg_kind   = MSG_RELEASE;
          pend_nxt.out_button = in_data.button_id;
          pend_nxt.out_mask   = held_nxt;
        end
      endcase
    end

    if (cmd.rd_issue) begin
      rd_idx_nxt = (rd_idx_r == IDX_W'(RING_DEPTH - 1)) ? '0 : rd_idx_r + IDX_W'(1);
      fill_nxt   = fill_r - FILL_W'(1);
      cnt_nxt    = cnt_r - 4'd1;
    end

    if (cmd.load_pend) begin
      out_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end

    if (cmd.load_rd) begin
      out_nxt.msg_kind   = MSG_MOTION;
      out_nxt.out_dx     = rd_data_r.dx;
      out_nxt.out_dy     = rd_data_r.dy;
      out_nxt.out_button = 4'd0;
      out_nxt.out_mask   = rd_data_r.mask;
      out_nxt.last       = status.cnt_zero;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r     <= BURST_RESET;
      rd_idx_r    <= '0;
      wr_idx_r    <= '0;
      fill_r      <= '0;
      outst_r     <= '0;
      held_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      burst_r     <= burst_nxt;
      rd_idx_r    <= rd_idx_nxt;
      wr_idx_r    <= wr_idx_nxt;
      fill_r      <= fill_nxt;
      outst_r     <= outst_nxt;
      held_r      <= held_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_idx_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= ring[rd_idx_r];
    end
  end

endmodule

// ===== design/mouse_motion_credit_queue.sv =====
// Top level of the mouse motion credit queue: controller plus datapath.
// Motion, press, release and drop items: the result passes from the pending register to the
// output register in the emit state; the next item is accepted only after that output load.
// Acknowledge items: one ring memory read and one output load per drained entry, in the
// read and load states; the single ring read port drains the entries one at a time.
// Reset clears control, counters, button mask and sets burst limit to 4; ring data is not cleared.
module mouse_motion_credit_queue
  import mmcq_pkg::*;
#(
  parameter int RING_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  mmcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mmcq_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== test/mmcq_result_check.sv =====
// Predictor and result checker for the mouse motion credit queue channels.
module mmcq_result_check
  import mmcq_pkg::*;
#(
  parameter int RING_SLOTS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  input  logic      cfg_we,
  input  logic [3:0] cfg_wdata,
  output int        fails,
  output int        pending,
  output int        results_seen,
  output int        drops_seen
);

  ring_entry_t motion_slots [RING_SLOTS];
  logic [5:0]  rd_ptr;
  logic [5:0]  wr_ptr;
  int          slots_used;
  int          credits_used;
  logic [2:0]  held;
  logic [3:0]  burst;
  out_item_t   expected_msgs [$];

  function automatic int usable_burst(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > 4'd8) return 8;
    return int'(v);
  endfunction

  function automatic logic [2:0] mask_of(input logic [3:0] btn);
    case (btn)
      BTN_LEFT:   return 3'b001;
      BTN_MIDDLE: return 3'b010;
      BTN_RIGHT:  return 3'b100;
      default:    return 3'b000;
    endcase
  endfunction

  task automatic predict_item(input in_item_t it);
    int        lim;
    int        drained;
    out_item_t msg;
    lim = usable_burst(burst);
    msg = '0;
    case (it.mode)
      MODE_MOTION: begin
        if (credits_used >= lim) begin
          if (slots_used >= RING_SLOTS) begin
            msg.msg_kind = MSG_DROP;
            msg.out_mask = held;
            msg.last = 1'b1;
            expected_msgs.push_back(msg);
          end else begin
            motion_slots[wr_ptr] = '{dx: it.delta_x, dy: it.delta_y, mask: held};
            wr_ptr++;
            slots_used++;
          end
        end else begin
          credits_used++;
          msg.msg_kind = MSG_MOTION;
          msg.out_dx = it.delta_x;
          msg.out_dy = it.delta_y;
          msg.out_mask = held;
          msg.last = 1'b1;
          expected_msgs.push_back(msg);
        end
      end
      MODE_ACK: begin
        drained = 0;
        while (slots_used > 0 && drained < lim) begin
          msg = '0;
          msg.msg_kind = MSG_MOTION;
          msg.out_dx = motion_slots[rd_ptr].dx;
          msg.out_dy = motion_slots[rd_ptr].dy;
          msg.out_mask = motion_slots[rd_ptr].mask;
          msg.last = (slots_used == 1) || (drained + 1 == lim);
          expected_msgs.push_back(msg);
          rd_ptr++;
          slots_used--;
          drained++;
        end
        credits_used = drained;
      end
      MODE_PRESS: begin
        held = held | mask_of(it.button_id);
        msg.msg_kind = MSG_PRESS;
        msg.out_button = it.button_id;
        msg.out_mask = held;
        msg.last = 1'b1;
        expected_msgs.push_back(msg);
      end
      default: begin
        held = held & ~mask_of(it.button_id);
        msg.msg_kind = MSG_RELEASE;
        msg.out_button = it.button_id;
        msg.out_mask = held;
        msg.last = 1'b1;
        expected_msgs.push_back(msg);
      end
    endcase
  endtask

  task automatic note_mismatch(input string fld, input logic [15:0] want,
                               input logic [15:0] got);
    $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, fld, want, got);
    fails++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    results_seen++;
    if (got.msg_kind == MSG_DROP) drops_seen++;
    if (expected_msgs.size() == 0) begin
      $display("%0t: unexpected item, expected none, got 'h%0h", $time, got);
      fails++;
    end else begin
      want = expected_msgs.pop_front();
      if (got.msg_kind !== want.msg_kind)
        note_mismatch("msg_kind", 16'(want.msg_kind), 16'(got.msg_kind));
      if (got.out_dx !== want.out_dx) note_mismatch("out_dx", want.out_dx, got.out_dx);
      if (got.out_dy !== want.out_dy) note_mismatch("out_dy", want.out_dy, got.out_dy);
      if (got.out_button !== want.out_button)
        note_mismatch("out_button", 16'(want.out_button), 16'(got.out_button));
      if (got.out_mask !== want.out_mask)
        note_mismatch("out_mask", 16'(want.out_mask), 16'(got.out_mask));
      if (got.last !== want.last)
        note_mismatch("last", 16'(want.last), 16'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr = '0;
      wr_ptr = '0;
      slots_used = 0;
      credits_used = 0;
      held = '0;
      burst = BURST_RESET;
      expected_msgs.delete();
      fails = 0;
      results_seen = 0;
      drops_seen = 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict_item(in_data);
      if (cfg_we) burst = cfg_wdata;
    end
    pending = expected_msgs.size();
  end

endmodule

// ===== test/mouse_motion_credit_queue_test.sv =====
// Stimulus, configuration phases and verdict for the mouse motion credit queue.
module mouse_motion_credit_queue_test;
  import mmcq_pkg::*;

  localparam int DRAIN_GUARD = 24;
  localparam int FLOOD_LEN   = 70;
  localparam int PHASE_LEN   = 36;
  localparam int PHASES      = 8;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_item_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic       in_stall;
  logic       out_valid;
  out_item_t  out_data;

  bit         calm = 1'b0;
  int         items_sent = 0;
  int         fails;
  int         pending;
  int         results_seen;
  int         drops_seen;
  logic [3:0] burst_plan [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd6, 4'd2};

  always #4 clk = ~clk;

  mouse_motion_credit_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  mmcq_result_check u_result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fails       (fails),
    .pending     (pending),
    .results_seen(results_seen),
    .drops_seen  (drops_seen)
  );

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 6);
  end

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [15:0] dx,
                                         input logic [15:0] dy, input logic [3:0] btn);
    in_item_t it;
    it.mode = mode;
    it.delta_x = dx;
    it.delta_y = dy;
    it.button_id = btn;
    return it;
  endfunction

  function automatic logic [15:0] rand_delta();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 50) it.mode = MODE_MOTION;
    else if (pick < 68) it.mode = MODE_ACK;
    else if (pick < 84) it.mode = MODE_PRESS;
    else it.mode = MODE_RELEASE;
    it.delta_x = rand_delta();
    it.delta_y = rand_delta();
    if ($urandom_range(3) == 0) it.button_id = 4'($urandom_range(15));
    else it.button_id = 4'($urandom_range(3, 1));
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  task automatic write_burst(input logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    in_item_t opening [20];
    opening = '{
      make_item(MODE_MOTION, 16'h7fff, 16'h8000, 4'd0),
      make_item(MODE_PRESS, 16'h0000, 16'h0000, BTN_LEFT),
      make_item(MODE_MOTION, 16'h8000, 16'h7fff, 4'd15),
      make_item(MODE_PRESS, 16'hffff, 16'hffff, BTN_MIDDLE),
      make_item(MODE_PRESS, 16'h0000, 16'h0000, BTN_RIGHT),
      make_item(MODE_MOTION, 16'h0000, 16'h0000, 4'd0),
      make_item(MODE_MOTION, 16'hffff, 16'hffff, 4'd0),
      make_item(MODE_MOTION, 16'h5555, 16'haaaa, 4'd0),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, BTN_MIDDLE),
      make_item(MODE_MOTION, 16'h1234, 16'h8001, 4'd0),
      make_item(MODE_PRESS, 16'h0000, 16'h0000, 4'd0),
      make_item(MODE_PRESS, 16'h0000, 16'h0000, 4'd15),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, 4'd4),
      make_item(MODE_ACK, 16'h7fff, 16'h7fff, 4'd0),
      make_item(MODE_ACK, 16'h0000, 16'h0000, 4'd0),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, BTN_LEFT),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, BTN_RIGHT),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, BTN_RIGHT),
      make_item(MODE_RELEASE, 16'h0000, 16'h0000, 4'd10),
      make_item(MODE_MOTION, 16'h7fff, 16'h7fff, 4'd5)
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    foreach (opening[i]) send_item(opening[i]);
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_burst(burst_plan[p]);
      calm = (p == 3);
      if (p == 0) begin
        repeat (FLOOD_LEN)
          send_item(make_item(MODE_MOTION, rand_delta(), rand_delta(),
                              4'($urandom_range(15))));
      end
      repeat (PHASE_LEN) send_item(rand_item());
    end
    calm = 1'b0;
    wait_drained();
    $display("Sent %0d items across %0d burst settings plus reset default.", items_sent, PHASES);
    $display("Checked %0d results, %0d of them queue-full drops.", results_seen, drops_seen);
    if (fails == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== mouse_motion_credit_queue.f =====
design/mmcq_pkg.sv
design/mmcq_ctrl.sv
design/mmcq_datapath.sv
design/mouse_motion_credit_queue.sv
test/mmcq_result_check.sv
test/mouse_motion_credit_queue_test.sv
